### sv/lcf_pkg.sv
package lcf_pkg;

    localparam int DIM_BITS = 12;
    localparam int PT_W     = 15;
    // point differences are one bit wider than the points
    localparam int DIF_W    = PT_W + 1;
    // numerator width: c1 and c1 - b1*dim, with headroom
    localparam int NUM_W    = 2 * PT_W + DIM_BITS - 8 + 4;
    // quotient bits: one more than a dimension, so dim itself can be exceeded
    localparam int QB       = DIM_BITS + 1;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

    localparam logic [DIM_BITS-1:0] FRAME_WIDTH_RST  = DIM_BITS'(640);
    localparam logic [DIM_BITS-1:0] FRAME_HEIGHT_RST = DIM_BITS'(480);

    localparam int IN_DATA_W  = ((4 * PT_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((4 * DIM_BITS + 7) / 8) * 8;

    typedef logic [DIM_BITS-1:0] dim_t;

    typedef struct packed {
        logic hit;
        dim_t q;
    } div_res_t;

endpackage

### sv/lcf_div.sv
module lcf_div (
    input  logic                              clk,
    input  logic                              en,
    input  logic signed [lcf_pkg::NUM_W-1:0]  num,
    input  logic signed [lcf_pkg::DIF_W-1:0]  den,
    input  lcf_pkg::dim_t                     lim,
    output lcf_pkg::div_res_t                 res
);
    import lcf_pkg::*;

    // truncating quotient, range checked against [0, lim]; one quotient bit a stage
    logic                 ok_reg   [0:QB];
    logic                 neg_reg  [0:QB];
    logic [NUM_W-1:0]     rem_reg  [0:QB];
    logic [NUM_W-1:0]     den_reg  [0:QB];
    logic [QB-1:0]        q_reg    [0:QB];
    dim_t                 lim_reg  [0:QB];

    logic [NUM_W-1:0] nabs;
    logic [NUM_W-1:0] dabs;
    logic             ovf;

    always_comb
    begin
        nabs = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
        dabs = NUM_W'(den[DIF_W-1] ? DIF_W'(-den) : DIF_W'(den));
        ovf  = nabs >= (dabs << QB);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ok_reg[0]  <= (den != '0) && (lim != '0) && !ovf;
            neg_reg[0] <= num[NUM_W-1] ^ den[DIF_W-1];
            rem_reg[0] <= nabs;
            den_reg[0] <= dabs;
            q_reg[0]   <= '0;
            lim_reg[0] <= lim;
        end
    end

    for (genvar k = 0; k < QB; k++)
    begin : g_step
        logic [NUM_W:0] trial;
        logic [QB-1:0]  q_next;

        always_comb
        begin
            trial  = {1'b0, rem_reg[k]} - {1'b0, (den_reg[k] << (QB - 1 - k))};
            q_next = q_reg[k];
            q_next[QB-1-k] = !trial[NUM_W];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ok_reg[k+1]  <= ok_reg[k];
                neg_reg[k+1] <= neg_reg[k];
                rem_reg[k+1] <= trial[NUM_W] ? rem_reg[k] : trial[NUM_W-1:0];
                den_reg[k+1] <= den_reg[k];
                q_reg[k+1]   <= q_next;
                lim_reg[k+1] <= lim_reg[k];
            end
        end
    end

    always_comb
    begin
        res.hit = ok_reg[QB] && ((q_reg[QB] == '0) ||
                  (!neg_reg[QB] && (q_reg[QB] <= {1'b0, lim_reg[QB]})));
        res.q   = q_reg[QB][DIM_BITS-1:0];
    end

endmodule

### sv/line_clip_to_frame_unit.sv
// An input line passes through the arithmetic stages, the divider stages and the output register.
// Throughput: one line per cycle while the output is not stalled; four restoring dividers, one quotient bit per stage.
// The whole pipeline advances together whenever the output register is free or taken.
// Reset (rst_n, asynchronous, active low) empties the pipeline and loads the
// frame registers with 640 by 480.
module line_clip_to_frame_unit (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // config write channel
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [lcf_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [lcf_pkg::DIM_BITS-1:0]           cfg_data,
    // input lines
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // point_a_x, point_a_y, point_b_x, point_b_y (lowest first)
    input  logic [lcf_pkg::IN_DATA_W-1:0]          s_tdata,
    // clipped segments
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // clip_start_x, clip_start_y, clip_end_x, clip_end_y (lowest first)
    output logic [lcf_pkg::OUT_DATA_W-1:0]         m_tdata,
    // inside_found
    output logic                                   m_tuser
);
    import lcf_pkg::*;

    // valid bits: four arithmetic stages, then QB+1 divider stages
    localparam int LAT = 4 + QB + 1;

    dim_t frame_width_reg;
    dim_t frame_height_reg;

    logic [LAT-1:0] vld_reg;
    logic           en;

    // stage 0: differences
    logic signed [DIF_W-1:0] a1_0_reg, b1_0_reg;
    logic signed [PT_W-1:0]  ax_0_reg, ay_0_reg;
    // stage 1: products
    logic signed [DIF_W-1:0] a1_1_reg, b1_1_reg;
    logic signed [NUM_W-1:0] pa_1_reg, pb_1_reg, bh_1_reg, aw_1_reg;
    // stage 2: c1 = a1*ax + b1*ay
    logic signed [DIF_W-1:0] a1_2_reg, b1_2_reg;
    logic signed [NUM_W-1:0] c1_2_reg, bh_2_reg, aw_2_reg;
    // stage 3: numerators per border
    logic signed [DIF_W-1:0] a1_3_reg, b1_3_reg;
    logic signed [NUM_W-1:0] c1_3_reg, nbot_3_reg, nrgt_3_reg;

    div_res_t res_left, res_top, res_bot, res_rgt;

    logic [OUT_DATA_W-1:0] tdata_reg, tdata_next;
    logic                  found_reg, found_next;
    logic                  tvalid_reg;

    assign en        = !tvalid_reg || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = tvalid_reg;
    assign m_tdata   = tdata_reg;
    assign m_tuser   = found_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            tvalid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg    <= {vld_reg[LAT-2:0], s_tvalid};
            tvalid_reg <= vld_reg[LAT-1];
        end
    end

    // arithmetic front end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a1_0_reg <= $signed({s_tdata[4*PT_W-1], s_tdata[4*PT_W-1:3*PT_W]})
                      - $signed({s_tdata[2*PT_W-1], s_tdata[2*PT_W-1:PT_W]});
            b1_0_reg <= $signed({s_tdata[PT_W-1], s_tdata[PT_W-1:0]})
                      - $signed({s_tdata[3*PT_W-1], s_tdata[3*PT_W-1:2*PT_W]});
            ax_0_reg <= $signed(s_tdata[PT_W-1:0]);
            ay_0_reg <= $signed(s_tdata[2*PT_W-1:PT_W]);

            a1_1_reg <= a1_0_reg;
            b1_1_reg <= b1_0_reg;
            pa_1_reg <= NUM_W'(a1_0_reg * ax_0_reg);
            pb_1_reg <= NUM_W'(b1_0_reg * ay_0_reg);
            bh_1_reg <= NUM_W'(b1_0_reg * $signed({1'b0, frame_height_reg}));
            aw_1_reg <= NUM_W'(a1_0_reg * $signed({1'b0, frame_width_reg}));

            a1_2_reg <= a1_1_reg;
            b1_2_reg <= b1_1_reg;
            c1_2_reg <= pa_1_reg + pb_1_reg;
            bh_2_reg <= bh_1_reg;
            aw_2_reg <= aw_1_reg;

            a1_3_reg   <= a1_2_reg;
            b1_3_reg   <= b1_2_reg;
            c1_3_reg   <= c1_2_reg;
            nbot_3_reg <= c1_2_reg - bh_2_reg;
            nrgt_3_reg <= c1_2_reg - aw_2_reg;
        end
    end

    // left: y = c1/b1, top: x = c1/a1, bottom: x = (c1-b1*h)/a1, right: y = (c1-a1*w)/b1
    lcf_div u_div_left (
        .clk(clk), .en(en), .num(c1_3_reg), .den(b1_3_reg),
        .lim(frame_height_reg), .res(res_left)
    );
    lcf_div u_div_top (
        .clk(clk), .en(en), .num(c1_3_reg), .den(a1_3_reg),
        .lim(frame_width_reg), .res(res_top)
    );
    lcf_div u_div_bot (
        .clk(clk), .en(en), .num(nbot_3_reg), .den(a1_3_reg),
        .lim(frame_width_reg), .res(res_bot)
    );
    lcf_div u_div_rgt (
        .clk(clk), .en(en), .num(nrgt_3_reg), .den(b1_3_reg),
        .lim(frame_height_reg), .res(res_rgt)
    );

    // hit ordering: left, top, bottom, then right only once a start exists
    always_comb
    begin
        dim_t sx, sy, ex, ey;
        logic have, done;
        sx = '0; sy = '0; ex = '0; ey = '0;
        have = 1'b0; done = 1'b0;
        if (res_left.hit)
        begin
            sx = '0; sy = res_left.q; have = 1'b1;
        end
        if (res_top.hit)
        begin
            if (!have)
            begin
                sx = res_top.q; sy = '0; have = 1'b1;
            end
            else
            begin
                ex = res_top.q; ey = '0; done = 1'b1;
            end
        end
        if (!done && res_bot.hit)
        begin
            if (!have)
            begin
                sx = res_bot.q; sy = frame_height_reg; have = 1'b1;
            end
            else
            begin
                ex = res_bot.q; ey = frame_height_reg; done = 1'b1;
            end
        end
        if (!done && have && res_rgt.hit)
        begin
            ex = frame_width_reg; ey = res_rgt.q; done = 1'b1;
        end
        found_next = done;
        tdata_next = done ? OUT_DATA_W'({ey, ex, sy, sx}) : '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tdata_reg <= tdata_next;
            found_reg <= found_next;
        end
    end

`ifndef SYNTH
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> vld_reg[0])
        else $error("accepted line did not enter the pipeline");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("result without hit pair carries non-zero endpoints");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("pipeline moved during a stall");
`endif

endmodule
